FILE: sv/sfpa_pkg.sv
// Shared types, constants and helpers for the saturating fixed-point ALU.
// No dependencies; every other file imports this package.
package sfpa_pkg;

  // Number of fraction bits in the raw fixed-point format (Q24.8)
  localparam int unsigned FracBits  = 8;
  localparam int unsigned DivStages = 32;

  typedef enum logic [3:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_DIV = 4'd3,
    CMD_MIN = 4'd4,
    CMD_MAX = 4'd5,
    CMD_INC = 4'd6,
    CMD_DEC = 4'd7,
    CMD_I2F = 4'd8,
    CMD_F2I = 4'd9
  } cmd_e;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } clamp_t;

  // Per-request payload carried through the pipeline
  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] res;     // result of all commands but multiply and divide
    logic               sat;
    logic               dz;
    logic               lt;
    logic               eq;
    logic               gt;
    logic               q_neg;   // quotient sign
    logic               a_neg;
    logic               a_zero;
    logic               ovf;     // quotient magnitude needs more than 32 bits
    logic signed [63:0] prod;    // full product a*b
    logic [31:0]        rem;     // partial remainder
    logic [31:0]        num_lo;  // dividend bits still to shift in
    logic [31:0]        den;     // divisor magnitude
    logic [31:0]        quo;     // quotient magnitude bits
  } pipe_t;

  // Clamp a 64-bit signed value to the signed 32-bit range
  function automatic clamp_t sat32(input logic signed [63:0] v);
    clamp_t c;
    if (v > 64'sd2147483647) begin
      c.val = 32'sh7FFF_FFFF;
      c.sat = 1'b1;
    end else if (v < -64'sd2147483648) begin
      c.val = 32'sh8000_0000;
      c.sat = 1'b1;
    end else begin
      c.val = v[31:0];
      c.sat = 1'b0;
    end
    return c;
  endfunction

endpackage

FILE: sv/sfpa_front.sv
// Input stage: decodes the request, does all commands but multiply and divide,
// the 32x32 product and the divider setup. Depends on sfpa_pkg.
module sfpa_front import sfpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [71:0] data_i,   // command[3:0], operand_a[35:4], operand_b[67:36]
  output logic        valid_o,
  input  logic        ready_i,
  output pipe_t       data_o
);

  logic               valid_q;
  pipe_t              data_q, data_d;
  logic signed [31:0] a, b;
  logic [31:0]        mag_a, mag_b;
  logic [63:0]        num;
  clamp_t             c_add, c_sub, c_inc, c_dec, c_i2f;
  logic signed [32:0] f2i_sum;

  assign a = data_i[35:4];
  assign b = data_i[67:36];

  // Results of all commands but multiply and divide, and divider setup
  always_comb begin
    c_add   = sat32(64'(a) + 64'(b));
    c_sub   = sat32(64'(a) - 64'(b));
    c_inc   = sat32(64'(a) + 64'sd1);
    c_dec   = sat32(64'(a) - 64'sd1);
    c_i2f   = sat32(64'(a) <<< FracBits);
    f2i_sum = 33'(a) + (a[31] ? 33'sd2 ** FracBits - 33'sd1 : 33'sd0);
    mag_a   = a[31] ? 32'(-33'(a)) : 32'(a);
    mag_b   = b[31] ? 32'(-33'(b)) : 32'(b);
    num     = {32'd0, mag_a} << FracBits;

    data_d        = '0;
    data_d.cmd    = cmd_e'(data_i[3:0]);
    data_d.lt     = a < b;
    data_d.eq     = a == b;
    data_d.gt     = a > b;
    data_d.a_neg  = a[31];
    data_d.a_zero = a == 32'sd0;
    data_d.q_neg  = a[31] ^ b[31];
    data_d.dz     = (data_d.cmd == CMD_DIV) && (b == 32'sd0);
    data_d.ovf    = num[63:32] >= mag_b;
    data_d.prod   = 64'(a) * 64'(b);
    data_d.rem    = num[63:32];
    data_d.num_lo = num[31:0];
    data_d.den    = mag_b;
    case (data_d.cmd)
      CMD_ADD: begin data_d.res = c_add.val; data_d.sat = c_add.sat; end
      CMD_SUB: begin data_d.res = c_sub.val; data_d.sat = c_sub.sat; end
      CMD_INC: begin data_d.res = c_inc.val; data_d.sat = c_inc.sat; end
      CMD_DEC: begin data_d.res = c_dec.val; data_d.sat = c_dec.sat; end
      CMD_I2F: begin data_d.res = c_i2f.val; data_d.sat = c_i2f.sat; end
      CMD_MIN: data_d.res = (a < b) ? a : b;
      CMD_MAX: data_d.res = (a > b) ? a : b;
      CMD_F2I: data_d.res = 32'(f2i_sum >>> FracBits);
      default: data_d.res = '0;
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: sv/sfpa_div_stage.sv
// One restoring-division step: produces one quotient bit per stage.
// Depends on sfpa_pkg.
module sfpa_div_stage import sfpa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  pipe_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output pipe_t data_o
);

  logic        valid_q;
  pipe_t       data_q, data_d;
  logic [32:0] cand;
  logic        take;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    cand          = {data_i.rem, data_i.num_lo[31]};
    take          = cand >= {1'b0, data_i.den};
    data_d        = data_i;
    data_d.rem    = take ? 32'(cand - {1'b0, data_i.den}) : cand[31:0];
    data_d.num_lo = {data_i.num_lo[30:0], 1'b0};
    data_d.quo    = {data_i.quo[30:0], take};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: sv/sfpa_back.sv
// Output stage: scales and clamps the product, clamps the quotient, picks the
// result and holds the output register. Depends on sfpa_pkg.
module sfpa_back import sfpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  pipe_t       data_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [39:0] data_o
);

  logic               valid_q;
  logic [39:0]        data_q, data_d;
  logic signed [63:0] prod_b;
  clamp_t             c_mul, c_div;
  logic signed [31:0] res;
  logic               sat;

  always_comb begin
    // Product scaled down with truncation toward zero
    prod_b = data_i.prod + (data_i.prod[63] ? 64'sd2 ** FracBits - 64'sd1 : 64'sd0);
    c_mul  = sat32(prod_b >>> FracBits);

    // Quotient sign and range
    if (data_i.ovf) begin
      c_div.val = data_i.q_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      c_div.sat = 1'b1;
    end else begin
      c_div = sat32(data_i.q_neg ? -64'({32'd0, data_i.quo}) : 64'({32'd0, data_i.quo}));
    end

    case (data_i.cmd)
      CMD_MUL: begin res = c_mul.val; sat = c_mul.sat; end
      CMD_DIV: begin
        if (data_i.dz) begin
          res = data_i.a_zero ? 32'sd0 : (data_i.a_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
          sat = !data_i.a_zero;
        end else begin
          res = c_div.val;
          sat = c_div.sat;
        end
      end
      default: begin res = data_i.res; sat = data_i.sat; end
    endcase

    data_d = {3'b000, data_i.dz, sat, data_i.gt, data_i.eq, data_i.lt, res};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: sv/saturating_fixed_point_alu_unit.sv
// Top level of the saturating Q24.8 fixed-point ALU.
// Depends on sfpa_pkg, sfpa_front, sfpa_div_stage and sfpa_back.
//
//   channel   direction  payload
//   s_axis    in         command, operand_a, operand_b
//   m_axis    out        result, a_less, a_equal, a_greater, saturated, divide_by_zero
//
// One request per cycle while the output is not stalled. The pipeline has one
// input stage, 32 divider steps (one quotient bit each) and one output stage.
// Every command flows through all stages. Reset clears only the stage valid
// bits. Each stage takes new data when it is empty or its successor takes its
// data, so a stall at the output fills bubbles and loses nothing.
module saturating_fixed_point_alu_unit import sfpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // command[3:0], operand_a[35:4], operand_b[67:36]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // result[31:0], a_less, a_equal, a_greater,
                                        // saturated, divide_by_zero, zero pad
);

  logic  vld [DivStages+1];
  logic  rdy [DivStages+1];
  pipe_t dat [DivStages+1];

  sfpa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (s_axis_tdata_i),
    .valid_o (vld[0]),
    .ready_i (rdy[0]),
    .data_o  (dat[0])
  );

  // Divider chain
  for (genvar i = 0; i < DivStages; i++) begin : g_div
    sfpa_div_stage u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[i]),
      .ready_o (rdy[i]),
      .data_i  (dat[i]),
      .valid_o (vld[i+1]),
      .ready_i (rdy[i+1]),
      .data_o  (dat[i+1])
    );
  end

  sfpa_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[DivStages]),
    .ready_o (rdy[DivStages]),
    .data_i  (dat[DivStages]),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (m_axis_tdata_o)
  );

endmodule
